// ===== hw/rtl/periodic_task_tick_scheduler_defines.svh =====
// Assertion macros for the checker file of the tick scheduler.
`ifndef PERIODIC_TASK_TICK_SCHEDULER_DEFINES_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PTTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptts assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PTTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptts assertion failed");

`endif

// ===== hw/rtl/ptts_pkg.sv =====
`timescale 1ns / 1ps

package ptts_pkg;

    // Operation codes of the func field.
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_ADD     = 3'd1;
    localparam logic [2:0] OP_SUSPEND = 3'd2;
    localparam logic [2:0] OP_RESUME  = 3'd3;
    localparam logic [2:0] OP_REMOVE  = 3'd4;

    // Status codes of a result.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TAKEN   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // latch the accepted transaction
        logic scan_step;  // process one table slot of a tick
        logic do_op;      // apply a non-tick operation and load its result
        logic emit_fire;  // load the next fired slot into the output register
        logic emit_none;  // load the single no-fire result
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;  // the scan is at the last slot
        logic mask_any;   // at least one fired slot is still to be reported
        logic mask_one;   // exactly one fired slot is still to be reported
        logic out_free;   // the output register can take a result this cycle
    } sts_t;

endpackage

// ===== hw/rtl/ptts_ctrl.sv =====
`timescale 1ns / 1ps

module ptts_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [2:0]    func,
    output logic          in_stall,
    output ptts_pkg::cmd_t cmd,
    input  ptts_pkg::sts_t sts
);
    import ptts_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_OP,
        S_SCAN,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_stall_reg;
    logic   in_stall_next;

    // Next state and the command for the current cycle.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (func == OP_TICK) ? S_SCAN : S_OP;
                end
            end
            S_OP:
            begin
                if (sts.out_free)
                begin
                    cmd.do_op  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    if (sts.mask_any)
                    begin
                        cmd.emit_fire = 1'b1;
                        if (sts.mask_one)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.emit_none = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        in_stall_next = (state_next != S_IDLE);
    end

    // State and registered stall.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= in_stall_next;
        end
    end

    assign in_stall = in_stall_reg;

endmodule

// ===== hw/rtl/ptts_dp.sv =====
`timescale 1ns / 1ps

module ptts_dp
#(
    parameter int MAX_TASKS = 8
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic [2:0]     func,
    input  logic [3:0]     slot,
    input  logic [15:0]    period,
    input  logic [15:0]    first_delay,
    input  logic           out_stall,
    output logic           out_valid,
    output logic           fired,
    output logic [3:0]     fired_slot,
    output logic [1:0]     status,
    output logic           last,
    input  ptts_pkg::cmd_t cmd,
    output ptts_pkg::sts_t sts
);
    import ptts_pkg::*;

    localparam int         IDX_W   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam logic [5:0] MAX_T6  = 6'(MAX_TASKS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);

    // Task table.
    logic [MAX_TASKS-1:0] present_reg;
    logic [MAX_TASKS-1:0] running_reg;
    logic [15:0]          period_reg    [MAX_TASKS];
    logic [15:0]          countdown_reg [MAX_TASKS];

    // Captured transaction and scan state.
    logic [2:0]           func_reg;
    logic                 slot_ok_reg;
    logic [15:0]          period_in_reg;
    logic [15:0]          delay_in_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [MAX_TASKS-1:0] mask_reg;

    // Output register.
    logic                 out_valid_reg;
    logic                 fired_reg;
    logic [3:0]           fired_slot_reg;
    logic [1:0]           status_reg;
    logic                 last_reg;

    logic [4:0]           slot_m1;
    logic                 slot_ok;
    logic [15:0]          cd_cur;
    logic [MAX_TASKS-1:0] low_bit;
    logic [MAX_TASKS-1:0] mask_rest;
    logic [IDX_W-1:0]     ff_idx;
    logic [5:0]           ff_slot_wide;
    logic [1:0]           op_status;
    logic                 out_free;

    // Slot decode of the incoming transaction; a single table index serves both
    // the scan and the slot operations.
    assign slot_m1 = {1'b0, slot} - 5'd1;
    assign slot_ok = (slot != 4'd0) && ({2'b00, slot} <= MAX_T6);
    assign cd_cur  = countdown_reg[idx_reg];

    // Lowest pending fired slot, isolated and encoded.
    assign low_bit   = mask_reg & (-mask_reg);
    assign mask_rest = mask_reg ^ low_bit;

    always_comb
    begin
        ff_idx = '0;
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            if (low_bit[i])
            begin
                ff_idx = ff_idx | IDX_W'(i);
            end
        end
    end

    assign ff_slot_wide = 6'(ff_idx) + 6'd1;

    // Status of a non-tick operation. Unused codes always report success,
    // whatever the slot.
    always_comb
    begin
        op_status = ST_OK;
        if (func_reg > OP_REMOVE)
        begin
            op_status = ST_OK;
        end
        else if (!slot_ok_reg)
        begin
            op_status = ST_INVALID;
        end
        else if ((func_reg == OP_ADD) && present_reg[idx_reg])
        begin
            op_status = ST_TAKEN;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    // Capture of the accepted transaction and the scan index.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg      <= func;
            slot_ok_reg   <= slot_ok;
            period_in_reg <= period;
            delay_in_reg  <= first_delay;
            idx_reg       <= (func == OP_TICK) ? '0 : slot_m1[IDX_W-1:0];
        end
        else if (cmd.scan_step)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // Period store, written only by a successful add.
    always_ff @(posedge clk)
    begin
        if (cmd.do_op && slot_ok_reg && (func_reg == OP_ADD) && !present_reg[idx_reg])
        begin
            period_reg[idx_reg] <= period_in_reg;
        end
    end

    // Flags, countdowns and the fired mask.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            running_reg <= '0;
            mask_reg    <= '0;
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                countdown_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.capture)
            begin
                mask_reg <= '0;
            end
            else if (cmd.emit_fire)
            begin
                mask_reg <= mask_rest;
            end

            if (cmd.scan_step && running_reg[idx_reg])
            begin
                if (cd_cur == 16'd0)
                begin
                    if (present_reg[idx_reg])
                    begin
                        countdown_reg[idx_reg] <= period_reg[idx_reg] - 16'd1;
                        mask_reg[idx_reg]      <= 1'b1;
                    end
                end
                else
                begin
                    countdown_reg[idx_reg] <= cd_cur - 16'd1;
                end
            end

            if (cmd.do_op && slot_ok_reg)
            begin
                case (func_reg)
                    OP_ADD:
                    begin
                        if (!present_reg[idx_reg])
                        begin
                            countdown_reg[idx_reg] <= delay_in_reg;
                            running_reg[idx_reg]   <= 1'b1;
                            present_reg[idx_reg]   <= 1'b1;
                        end
                    end
                    OP_SUSPEND:
                    begin
                        running_reg[idx_reg] <= 1'b0;
                    end
                    OP_RESUME:
                    begin
                        running_reg[idx_reg] <= 1'b1;
                    end
                    OP_REMOVE:
                    begin
                        present_reg[idx_reg] <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.do_op || cmd.emit_fire || cmd.emit_none)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload, loaded only when the register is free.
    always_ff @(posedge clk)
    begin
        if (cmd.emit_fire)
        begin
            fired_reg      <= 1'b1;
            fired_slot_reg <= ff_slot_wide[3:0];
            status_reg     <= ST_OK;
            last_reg       <= (mask_rest == '0);
        end
        else if (cmd.do_op || cmd.emit_none)
        begin
            fired_reg      <= 1'b0;
            fired_slot_reg <= 4'd0;
            status_reg     <= cmd.do_op ? op_status : ST_OK;
            last_reg       <= 1'b1;
        end
    end

    assign sts.scan_last = (idx_reg == LAST_IDX);
    assign sts.mask_any  = (mask_reg != '0);
    assign sts.mask_one  = (mask_reg != '0) && (mask_rest == '0);
    assign sts.out_free  = out_free;

    assign out_valid  = out_valid_reg;
    assign fired      = fired_reg;
    assign fired_slot = fired_slot_reg;
    assign status     = status_reg;
    assign last       = last_reg;

endmodule

// ===== hw/rtl/periodic_task_tick_scheduler.sv =====
`timescale 1ns / 1ps
// Periodic task tick scheduler: a table of MAX_TASKS priority slots.
// Input channel (in_valid / in_stall) carries func, slot, period and
// first_delay; a transaction is taken when in_valid is high and in_stall low.
// Output channel (out_valid / out_stall) carries fired, fired_slot, status and
// last; last marks the final result of one input transaction.
// Add, suspend, resume and remove give one status result each. A tick scans
// the table one slot per cycle, slot 1 first, then reports each fired slot,
// one per cycle while the receiver does not stall, or one no-fire result.
// The single table read port of the scan sets the scan rate.
// The block takes a new transaction as soon as the previous one has put its
// final result into the output register, even while that result still waits.
// When the receiver stalls, the output register holds its result and the
// block waits; no result is dropped or repeated.
// Reset clears all slots: nothing present, nothing running, countdowns zero.

module periodic_task_tick_scheduler
#(
    parameter int MAX_TASKS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic [3:0]  slot,
    input  logic [15:0] period,
    input  logic [15:0] first_delay,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        fired,
    output logic [3:0]  fired_slot,
    output logic [1:0]  status,
    output logic        last
);
    import ptts_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer for accept, scan, report.
    ptts_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Task table, scan and output register.
    ptts_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .func        (func),
        .slot        (slot),
        .period      (period),
        .first_delay (first_delay),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .fired       (fired),
        .fired_slot  (fired_slot),
        .status      (status),
        .last        (last),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

// ===== hw/rtl/ptts_chk.sv =====
`timescale 1ns / 1ps
`include "periodic_task_tick_scheduler_defines.svh"

module ptts_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [2:0]  func,
    input logic [3:0]  slot,
    input logic [15:0] period,
    input logic [15:0] first_delay,
    input logic        out_valid,
    input logic        out_stall,
    input logic        fired,
    input logic [3:0]  fired_slot,
    input logic [1:0]  status,
    input logic        last
);
    import ptts_pkg::*;

    // A stalled input transaction keeps its payload.
    `PTTS_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, $stable({func, slot, period, first_delay}))

    // A stalled result stays in place.
    `PTTS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable({fired, fired_slot, status, last}))

    // A firing result always reports success.
    `PTTS_ASSERT_NOW(a_fire_ok, clk, rst_n, out_valid && fired, status == ST_OK)

    // A result without a firing is always the only and final one, with no slot.
    `PTTS_ASSERT_NOW(a_nofire_last, clk, rst_n, out_valid && !fired, last && (fired_slot == 4'd0))

    // Every accepted input transaction raises the input stall.
    `PTTS_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall)

endmodule

bind periodic_task_tick_scheduler ptts_chk u_ptts_chk (.*);

// ===== verif/periodic_task_tick_scheduler_tb.sv =====
`timescale 1ns / 1ps

module periodic_task_tick_scheduler_tb;

    import ptts_pkg::*;

    localparam int SLOTS          = 8;
    localparam int HALF_PERIOD    = 2;
    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_ITEMS   = 180;
    localparam int DRAIN_EVERY    = 60;
    localparam int SETTLE_CYCLES  = 4 * SLOTS + 8;
    localparam int WATCHDOG_LIMIT = 2000;

    // Codes 5 to 7 of func are unused and must act as no-ops.
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    // One result transaction of the output channel.
    typedef struct packed {
        logic       fired;
        logic [3:0] fired_slot;
        logic [1:0] status;
        logic       last;
    } sched_result_t;

    // Keeps a copy of the slot table and the results it still owes.
    class tick_sched_scoreboard;
        bit            slot_present   [SLOTS];
        bit            slot_running   [SLOTS];
        bit [15:0]     slot_period    [SLOTS];
        bit [15:0]     slot_countdown [SLOTS];
        sched_result_t owed_results   [$];
        int            fail_count;

        function new();
            int i;
            for (i = 0; i < SLOTS; i++)
            begin
                slot_present[i]   = 1'b0;
                slot_running[i]   = 1'b0;
                slot_period[i]    = '0;
                slot_countdown[i] = '0;
            end
            fail_count = 0;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // Updates the slot table for an accepted request and queues its results.
        function void apply_request(logic [2:0] f, logic [3:0] s, logic [15:0] p,
                                    logic [15:0] d);
            sched_result_t r;
            int            i;
            int            n_fired;
            int            idx;
            logic [1:0]    st;

            if (f == OP_TICK)
            begin
                n_fired = 0;
                for (i = 0; i < SLOTS; i++)
                begin
                    if (slot_running[i])
                    begin
                        if (slot_countdown[i] == 16'd0)
                        begin
                            // A removed slot that reached zero stays silent.
                            if (slot_present[i])
                            begin
                                slot_countdown[i] = slot_period[i] - 16'd1;
                                r.fired      = 1'b1;
                                r.fired_slot = 4'(i + 1);
                                r.status     = ST_OK;
                                r.last       = 1'b0;
                                owed_results.push_back(r);
                                n_fired++;
                            end
                        end
                        else
                        begin
                            slot_countdown[i] = slot_countdown[i] - 16'd1;
                        end
                    end
                end
                if (n_fired == 0)
                begin
                    r = '{fired: 1'b0, fired_slot: 4'd0, status: ST_OK, last: 1'b1};
                    owed_results.push_back(r);
                end
                else
                begin
                    owed_results[owed_results.size() - 1].last = 1'b1;
                end
                return;
            end

            st = ST_OK;
            if (f <= OP_REMOVE)
            begin
                if (s == 4'd0 || s > SLOTS)
                begin
                    st = ST_INVALID;
                end
                else
                begin
                    idx = int'(s) - 1;
                    case (f)
                        OP_ADD:
                        begin
                            if (slot_present[idx])
                            begin
                                st = ST_TAKEN;
                            end
                            else
                            begin
                                slot_period[idx]    = p;
                                slot_countdown[idx] = d;
                                slot_running[idx]   = 1'b1;
                                slot_present[idx]   = 1'b1;
                            end
                        end
                        OP_SUSPEND: slot_running[idx] = 1'b0;
                        OP_RESUME:  slot_running[idx] = 1'b1;
                        default:    slot_present[idx] = 1'b0;
                    endcase
                end
            end
            r = '{fired: 1'b0, fired_slot: 4'd0, status: st, last: 1'b1};
            owed_results.push_back(r);
        endfunction

        function void report(string field, int want, int got);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            fail_count++;
        endfunction

        // Compares an accepted result with the oldest one owed.
        function void check_result(logic f, logic [3:0] fs, logic [1:0] st, logic l);
            sched_result_t want;
            if (owed_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual fired %0b slot %0d",
                         $time, f, fs);
                fail_count++;
                return;
            end
            want = owed_results.pop_front();
            if (f !== want.fired)       report("fired", want.fired, f);
            if (fs !== want.fired_slot) report("fired_slot", want.fired_slot, fs);
            if (st !== want.status)     report("status", want.status, st);
            if (l !== want.last)        report("last", want.last, l);
        endfunction
    endclass

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [2:0]  func        = OP_TICK;
    logic [3:0]  slot        = 4'd0;
    logic [15:0] period      = 16'd0;
    logic [15:0] first_delay = 16'd0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic        fired;
    logic [3:0]  fired_slot;
    logic [1:0]  status;
    logic        last;

    tick_sched_scoreboard sb;
    int                   idle_cycles = 0;
    int                   burst_left  = 0;

    // Receiver stall pattern state.
    int   stall_mode  = 0;
    int   mode_left   = 0;
    int   stall_run   = 0;
    int   stall_phase = 0;
    logic next_stall;

    periodic_task_tick_scheduler #(.MAX_TASKS(SLOTS)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .slot        (slot),
        .period      (period),
        .first_delay (first_delay),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .fired       (fired),
        .fired_slot  (fired_slot),
        .status      (status),
        .last        (last)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Both channels are sampled here; a cycle with no transaction feeds the watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                sb.apply_request(func, slot, period, first_delay);
            end
            if (out_valid && !out_stall)
            begin
                sb.check_result(fired, fired_slot, status, last);
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("%0t: watchdog expired", $time);
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

    // The receiver switches among free running, light, heavy and periodic stalls.
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(32, 200);
        end
        else
        begin
            mode_left--;
        end
        stall_phase = (stall_phase + 1) % 3;
        case (stall_mode)
            0:       next_stall = 1'b0;
            1:       next_stall = ($urandom_range(0, 99) < 30);
            2:       next_stall = ($urandom_range(0, 99) < 75);
            default: next_stall = (stall_phase != 0);
        endcase
        if (stall_run >= 8)
        begin
            next_stall = 1'b0;
        end
        stall_run = next_stall ? stall_run + 1 : 0;
        out_stall <= next_stall;
    end

    // Presents one request and returns at the falling edge after its transaction.
    task automatic send_op(input logic [2:0] f, input logic [3:0] s,
                           input logic [15:0] p, input logic [15:0] d);
        in_valid    <= 1'b1;
        func        <= f;
        slot        <= s;
        period      <= p;
        first_delay <= d;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // The sender runs in bursts and idles for a random gap between them.
    task automatic sender_pause();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(0, 8);
        end
    endtask

    // Holds the sender off until every owed result has come back.
    task automatic wait_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
    endtask

    // Mostly small periods and delays so that slots fire often.
    function automatic logic [15:0] pick_count();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return 16'($urandom_range(0, 4));
        else if (roll < 8)
            return 16'($urandom_range(0, 20));
        else
            return 16'($urandom());
    endfunction

    task automatic pick_request(output logic [2:0] f, output logic [3:0] s,
                                output logic [15:0] p, output logic [15:0] d);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            f = OP_TICK;
        else if (roll < 62)
            f = OP_ADD;
        else if (roll < 72)
            f = OP_SUSPEND;
        else if (roll < 82)
            f = OP_RESUME;
        else if (roll < 95)
            f = OP_REMOVE;
        else
            f = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));

        // Now and then an out-of-range slot, either zero or above the table.
        if ($urandom_range(0, 9) == 0)
            s = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(SLOTS + 1, 15));
        else
            s = 4'($urandom_range(1, SLOTS));
        p = pick_count();
        d = pick_count();
    endtask

    task automatic run_directed();
        int i;
        // Empty table, bad slots and the field extremes.
        send_op(OP_TICK,    4'd0,  16'hFFFF, 16'hFFFF);
        send_op(OP_ADD,     4'd0,  16'd5,    16'd5);
        send_op(OP_ADD,     4'd15, 16'hFFFF, 16'hFFFF);
        send_op(OP_ADD,     4'd1,  16'd0,    16'd0);
        send_op(OP_ADD,     4'd8,  16'hFFFF, 16'hFFFF);
        send_op(OP_ADD,     4'd1,  16'd3,    16'd3);
        send_op(OP_ADD,     4'd2,  16'd1,    16'd0);
        send_op(OP_ADD,     4'd3,  16'd2,    16'd1);
        // Slot 1 has period zero, so its reload wraps.
        send_op(OP_TICK,    4'd0,  16'd0,    16'd0);
        send_op(OP_TICK,    4'd0,  16'd0,    16'd0);
        // Suspend and resume on empty slots only touch the running bit.
        send_op(OP_SUSPEND, 4'd5,  16'd0,    16'd0);
        send_op(OP_RESUME,  4'd6,  16'd0,    16'd0);
        // A removed slot keeps running but never fires.
        send_op(OP_REMOVE,  4'd2,  16'd0,    16'd0);
        send_op(OP_SUSPEND, 4'd3,  16'd0,    16'd0);
        send_op(OP_TICK,    4'd0,  16'd0,    16'd0);
        send_op(OP_RESUME,  4'd3,  16'd0,    16'd0);
        send_op(OP_SUSPEND, 4'd0,  16'd0,    16'd0);
        send_op(OP_RESUME,  4'd12, 16'd0,    16'd0);
        send_op(OP_REMOVE,  4'd9,  16'd0,    16'd0);
        // Unused codes are no-ops.
        send_op(OP_SPARE_FIRST, 4'd1, 16'hA5A5, 16'h5A5A);
        send_op(OP_SPARE_LAST,  4'd4, 16'h1234, 16'h4321);
        // Refill the table so that one tick reports many slots.
        send_op(OP_ADD,     4'd2,  16'd3,    16'd5);
        for (i = 4; i <= 7; i++)
        begin
            send_op(OP_ADD, 4'(i), 16'd1, 16'd0);
        end
        send_op(OP_TICK,    4'd0,  16'd0,    16'd0);
        send_op(OP_TICK,    4'd0,  16'd0,    16'd0);
    endtask

    task automatic run_random();
        int          n;
        logic [2:0]  f;
        logic [3:0]  s;
        logic [15:0] p;
        logic [15:0] d;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick_request(f, s, p, d);
            send_op(f, s, p, d);
            if (n % DRAIN_EVERY == DRAIN_EVERY - 1)
                wait_results();
            else
                sender_pause();
        end
    endtask

    initial
    begin
        sb = new();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        wait_results();
        run_random();
        wait_results();

        // Let any stray result show up before the verdict.
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (sb.fail_count == 0 && sb.pending() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== periodic_task_tick_scheduler.f =====
+incdir+hw/rtl
hw/rtl/ptts_pkg.sv
hw/rtl/ptts_ctrl.sv
hw/rtl/ptts_dp.sv
hw/rtl/periodic_task_tick_scheduler.sv
hw/rtl/ptts_chk.sv
verif/periodic_task_tick_scheduler_tb.sv
